// File: rtl/core/six_dof_serial_packet_decoder_macros.svh
// ----------------------------------------------------------------------------
// Six-DOF serial packet decoder: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SIX_DOF_SERIAL_PACKET_DECODER_MACROS_SVH
`define SIX_DOF_SERIAL_PACKET_DECODER_MACROS_SVH

// same-cycle implication
`define SDD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SDD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sixdof_dec_pkg.sv
// ----------------------------------------------------------------------------
// Six-DOF serial packet decoder: package
// Shared constants and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
package sixdof_dec_pkg;

    localparam int STORE_BYTES_DEF = 16;

    // source of a result loaded into the output register
    typedef enum logic [1:0] {
        EMIT_AXIS   = 2'd0,
        EMIT_BTN    = 2'd1,
        EMIT_FLUSH  = 2'd2,
        EMIT_SINGLE = 2'd3
    } emit_sel_t;

    typedef struct packed {
        logic       take;        // input request accepted this cycle
        logic       rd_en;       // read packet store
        logic [3:0] rd_idx;      // byte index to read
        logic       hi_load;     // capture previous read into holding byte
        logic [2:0] axis_sel;
        logic       axis_write;
        logic       btn_load;    // compute new button word and change mask
        logic       emit;
        emit_sel_t  emit_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic start_disp;
        logic start_btn;
        logic start_single;
        logic axis_changed;
        logic btn_any;
        logic btn_last;
        logic out_free;
    } dp_sts_t;

endpackage

// File: rtl/core/sixdof_dec_ctrl.sv
// ----------------------------------------------------------------------------
// Six-DOF serial packet decoder: controller
// Sequences packet-store reads and result emission after a packet completes.
// ----------------------------------------------------------------------------
`include "six_dof_serial_packet_decoder_macros.svh"

module sixdof_dec_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    output sixdof_dec_pkg::dp_cmd_t  cmd,
    input  sixdof_dec_pkg::dp_sts_t  sts
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_DISP_HI  = 10'b00_0000_0010,
        ST_DISP_LO  = 10'b00_0000_0100,
        ST_DISP_CMP = 10'b00_0000_1000,
        ST_FLUSH    = 10'b00_0001_0000,
        ST_BTN_RD1  = 10'b00_0010_0000,
        ST_BTN_RD2  = 10'b00_0100_0000,
        ST_BTN_CALC = 10'b00_1000_0000,
        ST_BTN_EMIT = 10'b01_0000_0000,
        ST_SINGLE   = 10'b10_0000_0000
    } state_t;

    localparam logic [3:0] FIRST_AXIS_BYTE = 4'd3;
    localparam logic [3:0] BTN_BYTE1       = 4'd1;
    localparam logic [3:0] BTN_BYTE2       = 4'd2;
    localparam logic [2:0] LAST_AXIS       = 3'd5;

    state_t     state_reg, state_next;
    logic [2:0] axis_cnt_reg, axis_cnt_next;
    logic       moved_reg, moved_next;

    always_comb
    begin
        state_next    = state_reg;
        axis_cnt_next = axis_cnt_reg;
        moved_next    = moved_reg;
        in_stall      = 1'b1;

        cmd            = '0;
        cmd.axis_sel   = axis_cnt_reg;
        cmd.emit_sel   = sixdof_dec_pkg::EMIT_AXIS;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
                if (in_valid)
                begin
                    if (sts.start_disp)
                    begin
                        state_next    = ST_DISP_HI;
                        axis_cnt_next = '0;
                        moved_next    = 1'b0;
                    end
                    else if (sts.start_btn)
                    begin
                        state_next = ST_BTN_RD1;
                    end
                    else if (sts.start_single)
                    begin
                        state_next = ST_SINGLE;
                    end
                end
            end
            ST_DISP_HI:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_idx = 4'({axis_cnt_reg, 1'b0}) + FIRST_AXIS_BYTE;
                state_next = ST_DISP_LO;
            end
            ST_DISP_LO:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_idx  = 4'({axis_cnt_reg, 1'b0}) + FIRST_AXIS_BYTE + 4'd1;
                cmd.hi_load = 1'b1;
                state_next  = ST_DISP_CMP;
            end
            ST_DISP_CMP:
            begin
                if (!sts.axis_changed || sts.out_free)
                begin
                    cmd.axis_write = 1'b1;
                    cmd.emit       = sts.axis_changed;
                    cmd.emit_sel   = sixdof_dec_pkg::EMIT_AXIS;
                    moved_next     = moved_reg | sts.axis_changed;
                    if (axis_cnt_reg == LAST_AXIS)
                    begin
                        state_next = moved_next ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        axis_cnt_next = axis_cnt_reg + 3'd1;
                        state_next    = ST_DISP_HI;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = sixdof_dec_pkg::EMIT_FLUSH;
                    state_next   = ST_IDLE;
                end
            end
            ST_BTN_RD1:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_idx = BTN_BYTE1;
                state_next = ST_BTN_RD2;
            end
            ST_BTN_RD2:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_idx  = BTN_BYTE2;
                cmd.hi_load = 1'b1;
                state_next  = ST_BTN_CALC;
            end
            ST_BTN_CALC:
            begin
                cmd.btn_load = 1'b1;
                state_next   = sts.btn_any ? ST_BTN_EMIT : ST_IDLE;
            end
            ST_BTN_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = sixdof_dec_pkg::EMIT_BTN;
                    if (sts.btn_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SINGLE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = sixdof_dec_pkg::EMIT_SINGLE;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            axis_cnt_reg <= '0;
            moved_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            axis_cnt_reg <= axis_cnt_next;
            moved_reg    <= moved_next;
        end
    end

    `SDD_ASSERT_IMP(a_emit_needs_slot, cmd.emit, sts.out_free, "result emitted into a full output register")
    `SDD_ASSERT_IMP(a_one_job, cmd.take, $onehot0({sts.start_disp, sts.start_btn, sts.start_single}), "more than one job started by one byte")
    `SDD_ASSERT_NXT(a_disp_start, cmd.take && sts.start_disp, state_reg == ST_DISP_HI && axis_cnt_reg == 3'd0, "displacement sequence did not start at axis zero")
    `SDD_ASSERT_IMP(a_flush_moved, state_reg == ST_FLUSH, moved_reg, "flush without a changed axis")

endmodule

// File: rtl/core/sixdof_dec_dp.sv
// ----------------------------------------------------------------------------
// Six-DOF serial packet decoder: datapath
// Escape removal, packet framing, packet store, axis/button state, output reg.
// ----------------------------------------------------------------------------
module sixdof_dec_dp #(
    parameter int STORE_BYTES = sixdof_dec_pkg::STORE_BYTES_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [7:0]               rx_byte,
    input  sixdof_dec_pkg::dp_cmd_t  cmd,
    output sixdof_dec_pkg::dp_sts_t  sts,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [2:0]               event_kind,
    output logic [3:0]               item_index,
    output logic signed [15:0]       item_value,
    output logic                     last
);

    localparam int AW = $clog2(STORE_BYTES);

    // characters
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_XON   = 8'h0B;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] LOW5_MASK = 8'h1F;

    // packet kinds
    localparam logic [3:0] PK_NONE   = 4'd0;
    localparam logic [3:0] PK_DISP   = 4'd1;
    localparam logic [3:0] PK_KEY    = 4'd2;
    localparam logic [3:0] PK_EXTKEY = 4'd3;
    localparam logic [3:0] PK_COMM   = 4'd4;
    localparam logic [3:0] PK_SENS   = 4'd5;
    localparam logic [3:0] PK_MOVE   = 4'd6;
    localparam logic [3:0] PK_NULL   = 4'd7;
    localparam logic [3:0] PK_RATE   = 4'd8;
    localparam logic [3:0] PK_XON    = 4'd9;
    localparam logic [3:0] PK_CR     = 4'd10;
    localparam logic [3:0] PK_RESET  = 4'd11;
    localparam logic [3:0] PK_ERROR  = 4'd12;
    localparam logic [3:0] PK_ZERO   = 4'd13;

    // result kinds
    localparam logic [2:0] EV_AXIS   = 3'd0;
    localparam logic [2:0] EV_BUTTON = 3'd1;
    localparam logic [2:0] EV_FLUSH  = 3'd2;
    localparam logic [2:0] EV_REINIT = 3'd3;
    localparam logic [2:0] EV_ERROR  = 3'd4;

    localparam logic [5:0] POS_MAX = 6'd63;

    // framing state
    logic       esc_reg;
    logic [5:0] pos_reg;
    logic [3:0] kind_reg;
    logic [5:0] len_reg;
    logic       ext_seen_reg;
    logic       job_ext_reg;
    logic       job_err_reg;

    // packet store
    logic [7:0] mem [STORE_BYTES];
    logic [7:0] rdata_reg;
    logic [7:0] hi_reg;

    // decoded state
    logic [15:0] axis_reg [6];
    logic [15:0] button_reg;
    logic [15:0] rem_reg;

    // output register
    logic               out_valid_reg;
    logic [2:0]         ev_kind_reg;
    logic [3:0]         ev_index_reg;
    logic signed [15:0] ev_value_reg;
    logic               ev_last_reg;

    // front end
    logic       esc_start;
    logic [7:0] c;
    logic       lead_ok;
    logic [3:0] lead_kind;
    logic [5:0] lead_len;
    logic       first;
    logic [3:0] kind_eff;
    logic [5:0] len_eff;
    logic [5:0] pos_inc;
    logic       proceed;
    logic       complete;
    logic       done;
    logic       store_wr;

    // sequencing
    logic [15:0] axis_word;
    logic [15:0] btn_next;
    logic [15:0] btn_diff;
    logic [15:0] low_bit;
    logic [3:0]  low_idx;
    logic        out_free;

    logic [2:0]         ev_kind_d;
    logic [3:0]         ev_index_d;
    logic signed [15:0] ev_value_d;
    logic               ev_last_d;

    always_comb
    begin
        esc_start = (rx_byte == CH_CARET) && !esc_reg;
        c = rx_byte;
        if (esc_reg && (rx_byte == CH_Q || rx_byte == CH_S || rx_byte == CH_M))
        begin
            c = rx_byte & LOW5_MASK;
        end

        lead_ok   = 1'b1;
        lead_kind = PK_NONE;
        lead_len  = 6'd1;
        case (c)
            CH_D:   begin lead_kind = PK_DISP;   lead_len = 6'd16; end
            CH_K:   begin lead_kind = PK_KEY;    lead_len = 6'd4;  end
            CH_DOT: begin lead_kind = PK_EXTKEY; lead_len = 6'd4;  end
            CH_C:   begin lead_kind = PK_COMM;   lead_len = 6'd4;  end
            CH_F:   begin lead_kind = PK_SENS;   lead_len = 6'd4;  end
            CH_M:   begin lead_kind = PK_MOVE;   lead_len = 6'd5;  end
            CH_N:   begin lead_kind = PK_NULL;   lead_len = 6'd3;  end
            CH_P:   begin lead_kind = PK_RATE;   lead_len = 6'd6;  end
            CH_XON: begin lead_kind = PK_XON;    lead_len = 6'd1;  end
            CH_LF:  begin lead_kind = PK_CR;     lead_len = 6'd1;  end
            CH_CR:  begin lead_kind = PK_CR;     lead_len = 6'd1;  end
            CH_AT:  begin lead_kind = PK_RESET;  lead_len = 6'd62; end
            CH_E:   begin lead_kind = PK_ERROR;  lead_len = 6'd8;  end
            CH_Z:   begin lead_kind = PK_ZERO;   lead_len = 6'd14; end
            default: lead_ok = 1'b0;
        endcase

        first    = (pos_reg == 6'd0);
        kind_eff = first ? lead_kind : kind_reg;
        len_eff  = first ? lead_len : len_reg;
        pos_inc  = (pos_reg != POS_MAX) ? pos_reg + 6'd1 : pos_reg;
        proceed  = cmd.take && !esc_start && (!first || lead_ok);

        // reset and error packets run until a carriage return
        if (kind_eff == PK_RESET || kind_eff == PK_ERROR)
        begin
            complete = (c == CH_CR);
        end
        else
        begin
            complete = (pos_inc == len_eff);
        end

        done     = proceed && complete;
        store_wr = proceed && ({1'b0, pos_reg} < 7'(STORE_BYTES));

        sts.start_disp   = done && (kind_eff == PK_DISP);
        // extended format completes on its fourth byte, which must be CR
        sts.start_btn    = done && ((kind_eff == PK_KEY && !ext_seen_reg) ||
                                    (kind_eff == PK_EXTKEY && c == CH_CR));
        sts.start_single = done && (kind_eff == PK_RESET || kind_eff == PK_ERROR);

        axis_word = {hi_reg, rdata_reg};

        // hi_reg holds byte 1, rdata_reg byte 2
        if (job_ext_reg)
        begin
            btn_next = {~hi_reg[5], 3'b000, hi_reg[4:0], rdata_reg[7], rdata_reg[5:0]};
        end
        else
        begin
            btn_next = {1'b0, hi_reg[5] | hi_reg[3], rdata_reg[5:4], 4'b0000,
                        hi_reg[4], hi_reg[2:0], rdata_reg[3:0]};
        end
        btn_diff = btn_next ^ button_reg;

        low_bit = rem_reg & (~rem_reg + 16'd1);
        low_idx = '0;
        for (int i = 15; i >= 0; i--)
        begin
            if (rem_reg[i])
            begin
                low_idx = 4'(i);
            end
        end

        out_free = !out_valid_reg || !out_stall;

        sts.axis_changed = (axis_word != axis_reg[cmd.axis_sel]);
        sts.btn_any      = (btn_diff != 16'd0);
        sts.btn_last     = ((rem_reg ^ low_bit) == 16'd0);
        sts.out_free     = out_free;

        ev_kind_d  = EV_AXIS;
        ev_index_d = '0;
        ev_value_d = '0;
        ev_last_d  = 1'b0;
        case (cmd.emit_sel)
            sixdof_dec_pkg::EMIT_AXIS:
            begin
                ev_kind_d  = EV_AXIS;
                ev_index_d = {1'b0, cmd.axis_sel};
                ev_value_d = axis_word;
            end
            sixdof_dec_pkg::EMIT_BTN:
            begin
                ev_kind_d  = EV_BUTTON;
                ev_index_d = low_idx;
                ev_value_d = {15'd0, button_reg[low_idx]};
                ev_last_d  = sts.btn_last;
            end
            sixdof_dec_pkg::EMIT_FLUSH:
            begin
                ev_kind_d = EV_FLUSH;
                ev_last_d = 1'b1;
            end
            sixdof_dec_pkg::EMIT_SINGLE:
            begin
                ev_kind_d = job_err_reg ? EV_ERROR : EV_REINIT;
                ev_last_d = 1'b1;
            end
            default:
            begin
                ev_kind_d = EV_AXIS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg       <= 1'b0;
            pos_reg       <= '0;
            kind_reg      <= PK_NONE;
            len_reg       <= 6'd1;
            ext_seen_reg  <= 1'b0;
            job_ext_reg   <= 1'b0;
            job_err_reg   <= 1'b0;
            button_reg    <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                axis_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.take)
            begin
                esc_reg <= esc_start;
            end
            if (proceed)
            begin
                if (complete)
                begin
                    pos_reg  <= '0;
                    kind_reg <= PK_NONE;
                    len_reg  <= 6'd1;
                end
                else
                begin
                    pos_reg  <= pos_inc;
                    kind_reg <= kind_eff;
                    len_reg  <= len_eff;
                end
            end
            if (done)
            begin
                job_ext_reg <= (kind_eff == PK_EXTKEY);
                job_err_reg <= (kind_eff == PK_ERROR);
                if (kind_eff == PK_EXTKEY && c == CH_CR)
                begin
                    ext_seen_reg <= 1'b1;
                end
                else if (kind_eff == PK_RESET)
                begin
                    ext_seen_reg <= 1'b0;
                end
            end
            if (cmd.axis_write)
            begin
                axis_reg[cmd.axis_sel] <= axis_word;
            end
            if (cmd.btn_load)
            begin
                button_reg <= btn_next;
                rem_reg    <= btn_diff;
            end
            else if (cmd.emit && cmd.emit_sel == sixdof_dec_pkg::EMIT_BTN)
            begin
                rem_reg <= rem_reg ^ low_bit;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // packet store and payload registers
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            mem[pos_reg[AW-1:0]] <= c;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[AW'(cmd.rd_idx)];
        end
        if (cmd.hi_load)
        begin
            hi_reg <= rdata_reg;
        end
        if (cmd.emit)
        begin
            ev_kind_reg  <= ev_kind_d;
            ev_index_reg <= ev_index_d;
            ev_value_reg <= ev_value_d;
            ev_last_reg  <= ev_last_d;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = ev_kind_reg;
    assign item_index = ev_index_reg;
    assign item_value = ev_value_reg;
    assign last       = ev_last_reg;

endmodule

// File: rtl/core/six_dof_serial_packet_decoder.sv
// ----------------------------------------------------------------------------
// Six-DOF serial packet decoder: top level
// Decodes escaped serial bytes into axis, button, flush, reinit and error results.
// ----------------------------------------------------------------------------
// A byte that does not start a job leaves the controller idle, and the next
// byte can be taken in the next cycle. A completed displacement, button, reset
// or error packet holds off input while its results are produced; the packet
// store has one registered read port. A displacement packet takes two store
// reads and one compare per axis, then a flush result when an axis changed; a
// button packet takes two store reads and a compare, then one result per
// changed button bit; a reset or error packet gives a single result.
// Each result leaves through a single output register, and a stalled output
// holds the sequence. The last result of a byte is flagged with last.

module six_dof_serial_packet_decoder #(
    parameter int STORE_BYTES = sixdof_dec_pkg::STORE_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         event_kind,
    output logic [3:0]         item_index,
    output logic signed [15:0] item_value,
    output logic               last
);

    sixdof_dec_pkg::dp_cmd_t cmd;
    sixdof_dec_pkg::dp_sts_t sts;

    sixdof_dec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    sixdof_dec_dp #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (rx_byte),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_kind (event_kind),
        .item_index (item_index),
        .item_value (item_value),
        .last       (last)
    );

endmodule

// File: tb/tb_six_dof_serial_packet_decoder.sv
// ----------------------------------------------------------------------------
// Six-DOF serial packet decoder: testbench
// Drives escaped serial bytes through valid/stall, predicts every axis, button,
// flush, reinit and error result in a behavioral decoder, and checks results in
// order. Directed packets come first, then random framed traffic with noise.
// ----------------------------------------------------------------------------
module tb_six_dof_serial_packet_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES = sixdof_dec_pkg::STORE_BYTES_DEF;
    localparam int POS_MAX     = 63;
    localparam int SETTLE      = 24;

    // result kinds
    localparam logic [2:0] EV_AXIS   = 3'd0;
    localparam logic [2:0] EV_BUTTON = 3'd1;
    localparam logic [2:0] EV_FLUSH  = 3'd2;
    localparam logic [2:0] EV_REINIT = 3'd3;
    localparam logic [2:0] EV_ERROR  = 3'd4;

    // framing and escape bytes
    localparam logic [7:0] CH_ESC  = 8'h5E;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_XON  = 8'h0B;
    localparam logic [7:0] CH_Q    = "Q";
    localparam logic [7:0] CH_S    = "S";
    localparam logic [7:0] CH_M    = "M";
    localparam logic [7:0] CTRL_Q  = 8'h11;
    localparam logic [7:0] CTRL_S  = 8'h13;
    localparam logic [7:0] ESC_BIT = 8'h40;

    localparam logic [7:0] LEAD_DISP   = "D";
    localparam logic [7:0] LEAD_KEY    = "K";
    localparam logic [7:0] LEAD_EXTKEY = ".";
    localparam logic [7:0] LEAD_COMM   = "C";
    localparam logic [7:0] LEAD_SENS   = "F";
    localparam logic [7:0] LEAD_MOVE   = "M";
    localparam logic [7:0] LEAD_NULL   = "N";
    localparam logic [7:0] LEAD_RATE   = "P";
    localparam logic [7:0] LEAD_RESET  = "@";
    localparam logic [7:0] LEAD_ERROR  = "E";
    localparam logic [7:0] LEAD_ZERO   = "Z";

    typedef enum logic [3:0] {
        PKT_NONE, PKT_DISP, PKT_KEY, PKT_EXTKEY, PKT_COMM, PKT_SENS, PKT_MOVE,
        PKT_NULL, PKT_RATE, PKT_XON, PKT_CR, PKT_RESET, PKT_ERROR, PKT_ZERO
    } pkt_kind_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  index;
        logic [15:0] value;
        logic        last;
    } dof_event_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         event_kind;
    logic [3:0]         item_index;
    logic signed [15:0] item_value;
    logic               last;

    // decoder state mirror
    logic        esc_pending;
    logic [5:0]  pkt_pos;
    pkt_kind_t   pkt_kind;
    logic [5:0]  pkt_len;
    logic [7:0]  pkt_store [STORE_BYTES];
    logic [15:0] axis_val [6];
    logic [15:0] btn_word;
    logic        ext_seen;

    dof_event_t  expected_events [$];
    logic [7:0]  frame_bytes [$];
    logic [15:0] disp_axes [6];

    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          rx_hold_cycles = 0;
    int unsigned bytes_sent = 0;
    int unsigned results_predicted = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned kind_seen [5] = '{0, 0, 0, 0, 0};

    six_dof_serial_packet_decoder #(
        .STORE_BYTES(STORE_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .event_kind(event_kind),
        .item_index(item_index),
        .item_value(item_value),
        .last      (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic decoder_reset();
        esc_pending = 1'b0;
        pkt_pos     = '0;
        pkt_kind    = PKT_NONE;
        pkt_len     = 6'd1;
        btn_word    = '0;
        ext_seen    = 1'b0;
        foreach (pkt_store[i]) pkt_store[i] = '0;
        foreach (axis_val[i]) axis_val[i] = '0;
    endtask

    // Unescape, frame and decode one received byte; queue the results it causes.
    task automatic decode_byte(input logic [7:0] raw);
        logic [7:0]  c;
        logic [15:0] w1;
        logic [15:0] w2;
        logic [15:0] nxt;
        logic [15:0] v;
        logic        btn_update;
        logic        moved;
        int          a;
        int          b;
        dof_event_t  ev;
        dof_event_t  evs [$];
        c = raw;
        btn_update = 1'b0;
        moved = 1'b0;
        nxt = '0;
        ev = '0;
        if (c == CH_ESC && !esc_pending)
        begin
            esc_pending = 1'b1;
            return;
        end
        if (esc_pending)
        begin
            esc_pending = 1'b0;
            if (c == CH_Q || c == CH_S || c == CH_M)
                c = c & 8'h1F;
        end
        if (pkt_pos == 6'd0)
        begin
            case (c)
                LEAD_DISP:    begin pkt_kind = PKT_DISP;   pkt_len = 6'd16; end
                LEAD_KEY:     begin pkt_kind = PKT_KEY;    pkt_len = 6'd4;  end
                LEAD_EXTKEY:  begin pkt_kind = PKT_EXTKEY; pkt_len = 6'd4;  end
                LEAD_COMM:    begin pkt_kind = PKT_COMM;   pkt_len = 6'd4;  end
                LEAD_SENS:    begin pkt_kind = PKT_SENS;   pkt_len = 6'd4;  end
                LEAD_MOVE:    begin pkt_kind = PKT_MOVE;   pkt_len = 6'd5;  end
                LEAD_NULL:    begin pkt_kind = PKT_NULL;   pkt_len = 6'd3;  end
                LEAD_RATE:    begin pkt_kind = PKT_RATE;   pkt_len = 6'd6;  end
                CH_XON:       begin pkt_kind = PKT_XON;    pkt_len = 6'd1;  end
                CH_LF, CH_CR: begin pkt_kind = PKT_CR;     pkt_len = 6'd1;  end
                LEAD_RESET:   begin pkt_kind = PKT_RESET;  pkt_len = 6'd62; end
                LEAD_ERROR:   begin pkt_kind = PKT_ERROR;  pkt_len = 6'd8;  end
                LEAD_ZERO:    begin pkt_kind = PKT_ZERO;   pkt_len = 6'd14; end
                default:      return;
            endcase
        end
        if (pkt_pos < STORE_BYTES)
            pkt_store[pkt_pos] = c;
        if (pkt_pos < POS_MAX)
            pkt_pos = pkt_pos + 6'd1;
        if (pkt_kind == PKT_RESET || pkt_kind == PKT_ERROR)
        begin
            if (c != CH_CR)
                return;
            pkt_len = pkt_pos;
        end
        else if (pkt_pos != pkt_len)
            return;

        w1 = {8'h00, pkt_store[1]};
        w2 = {8'h00, pkt_store[2]};
        case (pkt_kind)
            PKT_DISP:
            begin
                for (a = 0; a < 6; a++)
                begin
                    v = {pkt_store[3 + 2 * a], pkt_store[4 + 2 * a]};
                    if (v != axis_val[a])
                    begin
                        ev.kind = EV_AXIS;
                        ev.index = a[3:0];
                        ev.value = v;
                        evs.push_back(ev);
                        moved = 1'b1;
                    end
                    axis_val[a] = v;
                end
                if (moved)
                begin
                    ev.kind = EV_FLUSH;
                    ev.index = '0;
                    ev.value = '0;
                    evs.push_back(ev);
                end
            end
            PKT_KEY:
            begin
                if (!ext_seen)
                begin
                    nxt = ((w1 & 16'h10) << 3) | ((w1 & 16'h20) << 9) |
                          ((w1 & 16'h08) << 11) | ((w1 & 16'h07) << 4) |
                          ((w2 & 16'h30) << 8) | (w2 & 16'h0F);
                    btn_update = 1'b1;
                end
            end
            PKT_EXTKEY:
            begin
                // extended format only counts with CR as its closing byte
                if (pkt_store[3] == CH_CR)
                begin
                    nxt = (((~w1) & 16'h20) << 10) | ((w1 & 16'h1F) << 7) |
                          (w2 & 16'h3F) | ((w2 & 16'h80) >> 1);
                    ext_seen = 1'b1;
                    btn_update = 1'b1;
                end
            end
            PKT_RESET:
            begin
                ext_seen = 1'b0;
                ev.kind = EV_REINIT;
                evs.push_back(ev);
            end
            PKT_ERROR:
            begin
                ev.kind = EV_ERROR;
                evs.push_back(ev);
            end
            default: ;
        endcase
        if (btn_update)
        begin
            for (b = 0; b < 16; b++)
            begin
                if (nxt[b] != btn_word[b])
                begin
                    ev.kind = EV_BUTTON;
                    ev.index = b[3:0];
                    ev.value = {15'd0, nxt[b]};
                    evs.push_back(ev);
                end
            end
            btn_word = nxt;
        end
        pkt_pos = '0;
        pkt_kind = PKT_NONE;
        pkt_len = 6'd1;
        if (evs.size() > 0)
            evs[evs.size() - 1].last = 1'b1;
        foreach (evs[i])
        begin
            expected_events.push_back(evs[i]);
            results_predicted++;
        end
    endtask

    // one request on the input channel; valid stays up when the next follows at once
    task automatic send_raw(input logic [7:0] b);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (in_stall);
        decode_byte(b);
        bytes_sent++;
    endtask

    // send a decoded byte value, escaping it on the line where allowed
    task automatic send_value(input logic [7:0] v);
        if (v == CH_ESC)
        begin
            send_raw(CH_ESC);
            send_raw(CH_ESC);
        end
        else if ((v == CTRL_Q || v == CTRL_S || v == CH_CR) && $urandom_range(0, 1) == 1)
        begin
            send_raw(CH_ESC);
            send_raw(v | ESC_BIT);
        end
        else if (v != CH_Q && v != CH_S && v != CH_M && $urandom_range(0, 15) == 0)
        begin
            // escaped ordinary byte passes through
            send_raw(CH_ESC);
            send_raw(v);
        end
        else
            send_raw(v);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) send_value(frame_bytes[i]);
        frame_bytes.delete();
    endtask

    task automatic send_disp();
        frame_bytes.push_back(LEAD_DISP);
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        foreach (disp_axes[a])
        begin
            frame_bytes.push_back(disp_axes[a][15:8]);
            frame_bytes.push_back(disp_axes[a][7:0]);
        end
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        send_frame();
    endtask

    task automatic send_buttons(input logic [7:0] lead, input logic [7:0] b1,
                                input logic [7:0] b2, input logic [7:0] tail);
        frame_bytes.push_back(lead);
        frame_bytes.push_back(b1);
        frame_bytes.push_back(b2);
        frame_bytes.push_back(tail);
        send_frame();
    endtask

    // lead byte, body without CR, then the closing CR
    task automatic send_terminated(input logic [7:0] lead, input int body_len);
        logic [7:0] b;
        frame_bytes.push_back(lead);
        repeat (body_len)
        begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
            frame_bytes.push_back(b);
        end
        frame_bytes.push_back(CH_CR);
        send_frame();
    endtask

    task automatic send_fixed(input logic [7:0] lead, input int len);
        frame_bytes.push_back(lead);
        repeat (len - 1) frame_bytes.push_back(8'($urandom_range(0, 255)));
        send_frame();
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic test_escapes();
        send_raw(CH_ESC);           // doubled caret at packet start: dropped
        send_raw(CH_ESC);
        send_raw(CH_ESC);           // escaped Q gives a control byte, not a lead
        send_raw(CH_Q);
        send_raw(CH_ESC);           // escaped ordinary byte, still no lead
        send_raw("A");
        send_raw(LEAD_ERROR);
        send_raw(CH_ESC);
        send_raw(CH_S);
        send_raw(CH_ESC);
        send_raw(CH_ESC);
        send_raw(CH_ESC);           // escaped M is CR and closes the packet
        send_raw(CH_M);
        wait_drain();
    endtask

    task automatic test_displacement();
        disp_axes = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5E5E};
        send_disp();
        send_disp();                // nothing moved: no results, no flush
        disp_axes[3] = 16'h1234;
        send_disp();
        wait_drain();
    endtask

    task automatic test_buttons();
        send_buttons(LEAD_KEY, 8'h3F, 8'h3F, 8'($urandom_range(0, 255)));
        send_buttons(LEAD_KEY, 8'h00, 8'h00, 8'($urandom_range(0, 255)));
        send_buttons(LEAD_EXTKEY, 8'hFF, 8'hFF, 8'h00);  // bad tail: ignored
        send_buttons(LEAD_KEY, 8'h15, 8'h2A, 8'h00);     // still basic format
        send_buttons(LEAD_EXTKEY, 8'h1F, 8'hBF, CH_CR);  // sets every extended-format bit
        send_buttons(LEAD_KEY, 8'h3F, 8'h3F, 8'h00);     // ignored after extended
        send_terminated(LEAD_RESET, 2);
        send_buttons(LEAD_KEY, 8'h2A, 8'h15, 8'h00);
        send_buttons(LEAD_EXTKEY, 8'h20, 8'h00, CH_CR);
        wait_drain();
    endtask

    task automatic test_reset_error();
        send_terminated(LEAD_RESET, 0);
        send_terminated(LEAD_ERROR, 0);
        send_terminated(LEAD_RESET, 64);     // position saturates
        wait_drain();
    endtask

    task automatic test_ignored();
        send_fixed(LEAD_COMM, 4);
        send_fixed(LEAD_SENS, 4);
        send_fixed(LEAD_MOVE, 5);
        send_fixed(LEAD_NULL, 3);
        send_fixed(LEAD_RATE, 6);
        send_raw(CH_XON);
        send_raw(CH_CR);
        send_raw(CH_LF);
        send_fixed(LEAD_ZERO, 14);
        send_raw(8'h00);
        send_raw(8'hFF);
        disp_axes = '{16'h0102, 16'h0304, 16'h0506, 16'h0708, 16'h090A, 16'h0B0C};
        send_disp();
        wait_drain();
    endtask

    // receiver holds off while the sender keeps offering bytes back to back
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_hold_cycles = 300;
        foreach (disp_axes[a]) disp_axes[a] = ~axis_val[a];
        send_disp();
        send_buttons(LEAD_EXTKEY, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), CH_CR);
        send_terminated(LEAD_ERROR, 1);
        foreach (disp_axes[a]) disp_axes[a] = ~axis_val[a];
        send_disp();
        tx_idle_on = 1'b1;
        wait_drain();
    endtask

    task automatic test_random();
        int unsigned byte_goal;
        int unsigned result_goal;
        int          pick;
        int          n_pkt;
        logic [7:0]  tail;
        byte_goal = bytes_sent + 60;
        result_goal = results_predicted + 20;
        n_pkt = 0;
        while (bytes_sent < byte_goal || results_predicted < result_goal)
        begin
            if (n_pkt % 8 == 0)
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            n_pkt++;
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                foreach (disp_axes[a])
                begin
                    case ($urandom_range(0, 3))
                        0: disp_axes[a] = axis_val[a];
                        1: disp_axes[a] = 16'($urandom_range(0, 65535));
                        2: disp_axes[a] = ($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h7FFF;
                        default: disp_axes[a] = axis_val[a] + 16'($urandom_range(1, 3));
                    endcase
                end
                send_disp();
            end
            else if (pick < 45)
                send_buttons(LEAD_KEY, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            else if (pick < 65)
            begin
                tail = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : CH_CR;
                send_buttons(LEAD_EXTKEY, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), tail);
            end
            else if (pick < 72)
                send_terminated(LEAD_RESET, $urandom_range(0, 4));
            else if (pick < 78)
                send_terminated(LEAD_ERROR,
                                ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(0, 4));
            else if (pick < 88)
            begin
                case ($urandom_range(0, 8))
                    0: send_fixed(LEAD_COMM, 4);
                    1: send_fixed(LEAD_SENS, 4);
                    2: send_fixed(LEAD_MOVE, 5);
                    3: send_fixed(LEAD_NULL, 3);
                    4: send_fixed(LEAD_RATE, 6);
                    5: send_raw(CH_XON);
                    6: send_raw(CH_CR);
                    7: send_raw(CH_LF);
                    default: send_fixed(LEAD_ZERO, 14);
                endcase
            end
            else
            begin
                // line noise: may break framing of what follows
                repeat ($urandom_range(1, 3)) send_raw(8'($urandom_range(0, 255)));
            end
        end
        wait_drain();
    endtask

    // receive side: random stalls, plus a long hold when a test asks for one
    initial
    begin : rx_side
        int wait_cycles;
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                wait_cycles = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
                wait_cycles = rx_idle_on ? $urandom_range(0, 15) : 0;
            if (wait_cycles == 0)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid && rx_hold_cycles == 0);
        end
    end

    always @(posedge clk)
    begin : check_results
        dof_event_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
            begin
                $error("unexpected result: kind %0d index %0d value %0d last %0d",
                       event_kind, item_index, item_value, last);
                mismatches++;
            end
            else
            begin
                want = expected_events.pop_front();
                results_seen++;
                if (want.kind < 5)
                    kind_seen[want.kind]++;
                if (event_kind !== want.kind)
                begin
                    $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
                    mismatches++;
                end
                if (item_index !== want.index)
                begin
                    $error("item_index: expected %0d, got %0d", want.index, item_index);
                    mismatches++;
                end
                if (item_value !== want.value)
                begin
                    $error("item_value: expected %0d, got %0d",
                           $signed(want.value), item_value);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        decoder_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_escapes();
        test_displacement();
        test_buttons();
        test_reset_error();
        test_ignored();
        test_backpressure();
        test_random();
        repeat (16) @(posedge clk);
        if (expected_events.size() != 0)
            $error("%0d expected results never arrived", expected_events.size());
        $display("Sent %0d bytes (escapes, all packet kinds, noise, long hold-off);",
                 bytes_sent);
        $display("checked %0d results: %0d axis, %0d button, %0d flush, %0d reinit, %0d error",
                 results_seen, kind_seen[EV_AXIS], kind_seen[EV_BUTTON],
                 kind_seen[EV_FLUSH], kind_seen[EV_REINIT], kind_seen[EV_ERROR]);
        if (mismatches == 0 && expected_events.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
